### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the filter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types, register codes and the per-plane majority function.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // field and register widths
    localparam int PIXEL_W     = 8;
    localparam int WIDTH_W     = 9;
    localparam int HEIGHT_W    = 10;
    localparam int ROW_W       = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 10;
    localparam int WIN_TAPS    = 9;
    localparam int VOTE_LIMIT  = 4;

    // register reset values and lower clamp for both sizes
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 9'd208;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 10'd160;
    localparam int                  MIN_SIZE     = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // 3x3 window, tap 3*row+col, col 2 is the newest column
    typedef logic [WIN_TAPS-1:0][PIXEL_W-1:0] win_t;

    // per-item control carried alongside the pixel data
    typedef struct packed {
        logic emit;       // item yields a result
        logic interior;   // result pixel gets the majority vote
        logic frame_end;  // result is the frame's last pixel
    } ctrl_t;

    // majority of nine bits, separately in each bit plane
    function automatic pixel_t majority(input win_t win);
        pixel_t     res;
        logic [3:0] cnt;
        res = '0;
        for (int b = 0; b < PIXEL_W; b++) begin
            cnt = '0;
            for (int k = 0; k < WIN_TAPS; k++) begin
                cnt = cnt + 4'(win[k][b]);
            end
            res[b] = (cnt > 4'(VOTE_LIMIT));
        end
        return res;
    endfunction

endpackage

### sv/bmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_ctrl
// Size registers, raster position tracking and the stage-1 control register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmf_ctrl #(
    parameter int MAX_WIDTH = 256,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel handshake
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             s_drain,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // stage 1 to window stage
    input  logic                             advance,
    output logic                             load,
    output logic                             past_frame,
    output logic [AW-1:0]                    col_addr,
    output logic                             s1_valid,
    output bmf_pkg::ctrl_t                   s1_ctrl
);

    localparam int CW = ((AW > bmf_pkg::WIDTH_W) ? AW : bmf_pkg::WIDTH_W) + 1;
    localparam int RW = bmf_pkg::ROW_W;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MINW = CW'(bmf_pkg::MIN_SIZE);
    localparam logic [bmf_pkg::HEIGHT_W-1:0] MINH = bmf_pkg::HEIGHT_W'(bmf_pkg::MIN_SIZE);

    logic [bmf_pkg::WIDTH_W-1:0]  width_reg, width_next;
    logic [bmf_pkg::HEIGHT_W-1:0] height_reg, height_next;
    logic [AW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;
    logic                         s1_valid_reg, s1_valid_next;
    bmf_pkg::ctrl_t               s1_ctrl_reg, s1_ctrl_next;

    logic [CW-1:0]                w_eff, x, x_inc, ox;
    logic [bmf_pkg::HEIGHT_W-1:0] h_eff;
    logic [RW:0]                  h_ext, oy_ext;
    logic [RW-1:0]                oy;
    logic                         accept, ignore, wrap, cfg_wr, cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // effective sizes after clamping
    always_comb begin
        if (CW'(width_reg) < MINW) begin
            w_eff = MINW;
        end else if (CW'(width_reg) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = CW'(width_reg);
        end
        h_eff = (height_reg < MINH) ? MINH : height_reg;
        h_ext = (RW + 1)'(h_eff);
    end

    // position of the current item and of the result it yields
    always_comb begin
        x          = CW'(col_reg);
        x_inc      = x + CW'(1);
        wrap       = (x_inc >= w_eff);
        past_frame = (row_reg >= RW'(h_eff));
        ignore     = s_drain && !past_frame;
        s_tready   = !s1_valid_reg || advance;
        accept     = s_tvalid && s_tready;
        load       = accept && !ignore;

        if (x == '0) begin
            oy = row_reg - RW'(2);
            ox = w_eff - CW'(1);
        end else begin
            oy = row_reg - RW'(1);
            ox = x - CW'(1);
        end
        oy_ext = (RW + 1)'(oy);

        s1_ctrl_next.emit      = !((row_reg == '0) ||
                                   ((row_reg == RW'(1)) && (x == '0)));
        s1_ctrl_next.interior  = (oy != '0) && (oy_ext + (RW + 1)'(2) <= h_ext) &&
                                 (ox != '0) && (ox + CW'(2) <= w_eff);
        s1_ctrl_next.frame_end = (oy_ext + (RW + 1)'(1) >= h_ext) &&
                                 (ox == w_eff - CW'(1));
    end

    // register writes and position update
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cfg_hit     = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                bmf_pkg::REG_IMAGE_WIDTH: begin
                    width_next = cfg_data[bmf_pkg::WIDTH_W-1:0];
                    cfg_hit    = 1'b1;
                end
                bmf_pkg::REG_IMAGE_HEIGHT: begin
                    height_next = cfg_data[bmf_pkg::HEIGHT_W-1:0];
                    cfg_hit     = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (load) begin
            if (s1_ctrl_next.emit && s1_ctrl_next.frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = AW'(x_inc);
            end
        end
    end

    // stage 1 occupancy
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= bmf_pkg::RESET_WIDTH;
            height_reg   <= bmf_pkg::RESET_HEIGHT;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 control payload
    always_ff @(posedge aclk) begin
        if (load) begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    assign col_addr = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;

    `ASSERT_IMPL(a_col_within_row, aclk, aresetn, 1'b1, x < w_eff, "column beyond row width")
    `ASSERT_NEXT(a_frame_end_rewind, aclk, aresetn,
        load && s1_ctrl_next.emit && s1_ctrl_next.frame_end,
        (col_reg == '0) && (row_reg == '0), "frame end did not rewind position")
    `ASSERT_NEXT(a_stage1_hold, aclk, aresetn, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_ctrl_reg), "stalled stage 1 item lost")

endmodule

### sv/bmf_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_line_store
// Two row memories (previous row, row before) and the stage-1 data register.
// ----------------------------------------------------------------------------
module bmf_line_store #(
    parameter int MAX_WIDTH = 256,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [AW-1:0]   addr,
    input  bmf_pkg::pixel_t wr_pixel,
    output bmf_pkg::pixel_t above,
    output bmf_pkg::pixel_t below,
    output bmf_pkg::pixel_t pixel
);

    // lo: previous row, hi: the row before it
    bmf_pkg::pixel_t lo_mem [MAX_WIDTH];
    bmf_pkg::pixel_t hi_mem [MAX_WIDTH];

    bmf_pkg::pixel_t lo_q_reg, hi_q_reg, byp_data_reg, pix_reg;
    logic [AW-1:0]   pend_addr_reg;
    logic            pend_valid_reg, byp_reg;

    // previous row: read old entry and write new pixel at the same column
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_mem[addr]  <= wr_pixel;
            lo_q_reg      <= lo_mem[addr];
            hi_q_reg      <= hi_mem[addr];
            byp_reg       <= pend_valid_reg && (pend_addr_reg == addr);
            byp_data_reg  <= lo_q_reg;
            pix_reg       <= wr_pixel;
            pend_addr_reg <= addr;
        end
    end

    // row before: the entry moved out of the previous row lands in the cycle after its read
    always_ff @(posedge aclk) begin
        if (pend_valid_reg) begin
            hi_mem[pend_addr_reg] <= lo_q_reg;
        end
    end

    // pending move flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= en;
        end
    end

    assign above = byp_reg ? byp_data_reg : hi_q_reg;
    assign below = lo_q_reg;
    assign pixel = pix_reg;

endmodule

### sv/bmf_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_window
// 3x3 window shift, per-plane majority vote and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmf_window (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s1_valid,
    input  bmf_pkg::ctrl_t  s1_ctrl,
    input  bmf_pkg::pixel_t above,
    input  bmf_pkg::pixel_t below,
    input  bmf_pkg::pixel_t pixel,
    output logic            advance,
    output logic            m_tvalid,
    input  logic            m_tready,
    output bmf_pkg::pixel_t m_tdata,
    output logic            m_tlast
);

    bmf_pkg::win_t   win_reg, win_next;
    bmf_pkg::pixel_t result, m_tdata_reg;
    logic            m_tvalid_reg, m_tlast_reg;

    // stage 1 moves on when the result register is free or being drained
    assign advance = s1_valid && (!m_tvalid_reg || m_tready);

    // shift the window left and bring in the new column
    always_comb begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = above;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = below;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = pixel;
        result      = s1_ctrl.interior ? bmf_pkg::majority(win_next) : win_next[4];
    end

    // window and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            win_reg      <= win_next;
            m_tvalid_reg <= s1_ctrl.emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && s1_ctrl.emit) begin
            m_tdata_reg <= result;
            m_tlast_reg <= s1_ctrl.frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance && s1_ctrl.emit,
        m_tvalid_reg && (m_tlast_reg == $past(s1_ctrl.frame_end)), "result not loaded")
    `ASSERT_NEXT(a_no_spurious, aclk, aresetn, advance && !s1_ctrl.emit,
        !m_tvalid_reg, "result from an item that yields none")

endmodule

### sv/bitplane_majority_filter_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_majority_filter_3x3_top
// 3x3 majority filter applied separately to each bit plane of 8-bit pixels.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock unless the output stalls and gives at
// most one result per pixel transfer, through the stage-1 and result registers.
// The rate is set by the line store: each pixel does one read and one write in
// each of the two row memories (MAX_WIDTH entries each), with the move into the
// older row landing in the following cycle. Results trail the pixel stream by
// one row plus one pixel, so send width+1 drain transfers (s_tuser = 1) after a
// frame to flush it; m_tlast marks the frame's last pixel. Drain transfers
// inside a frame are dropped. Border rows and columns pass through unchanged.
// Write the size registers only while the block is idle; each write starts a
// new frame. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module bitplane_majority_filter_3x3_top #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_in
    input  logic                             s_tuser,   // [0] drain
    // filtered output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] pixel_out
    output logic                             m_tlast,
    // size register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic            advance, load, past_frame, s1_valid;
    logic [AW-1:0]   col_addr;
    bmf_pkg::ctrl_t  s1_ctrl;
    bmf_pkg::pixel_t wr_pixel, above, below, pixel;

    // pixels after the frame count as zero
    assign wr_pixel = past_frame ? '0 : s_tdata;

    bmf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_drain    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .load       (load),
        .past_frame (past_frame),
        .col_addr   (col_addr),
        .s1_valid   (s1_valid),
        .s1_ctrl    (s1_ctrl)
    );

    bmf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (load),
        .addr     (col_addr),
        .wr_pixel (wr_pixel),
        .above    (above),
        .below    (below),
        .pixel    (pixel)
    );

    bmf_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid),
        .s1_ctrl  (s1_ctrl),
        .above    (above),
        .below    (below),
        .pixel    (pixel),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
